### rtl/oversubscription_detector_macros.svh
// Assertion macros used by the oversubscription detector RTL.
`ifndef OVERSUBSCRIPTION_DETECTOR_MACROS_SVH
`define OVERSUBSCRIPTION_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ODET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odet assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ODET_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odet assertion failed");

`endif

### rtl/odet_pkg.sv
// Types, widths and constants of the oversubscription detector.
`timescale 1ns / 1ps
package odet_pkg;

  localparam int unsigned CTX_W      = 12;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned BACKOFF_W  = 6;
  localparam int unsigned HOLD_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  // Signed width that holds count minus one and contexts plus or minus a margin
  localparam int unsigned CMP_W      = CTX_W + 2;

  localparam logic [CNT_W-1:0]     CNT_MAX      = '1;
  localparam logic [BACKOFF_W-1:0] BACKOFF_MAX  = '1;
  localparam logic [HOLD_W-1:0]    HOLD_LOG_MAX = 4'd15;

  // Register reset values
  localparam logic [CTX_W-1:0]   RST_HW_CONTEXTS       = 12'd8;
  localparam logic [CTX_W-1:0]   RST_HIGH_MARGIN       = 12'd0;
  localparam logic [CTX_W-1:0]   RST_LOW_MARGIN        = 12'd0;
  localparam logic [SHIFT_W-1:0] RST_EXIT_SHIFT        = 4'd1;
  localparam logic [CNT_W-1:0]   RST_EXIT_REQUIRED_MAX = 16'd1024;
  localparam logic [CNT_W-1:0]   RST_EXIT_REQUIRED_MIN = 16'd1;
  localparam logic [CNT_W-1:0]   RST_SWITCH_LIMIT_HIGH = 16'd100;
  localparam logic [CNT_W-1:0]   RST_SWITCH_LIMIT_LOW  = 16'd10;

  // Input item kinds
  typedef enum logic {
    ACT_SAMPLE     = 1'b0,
    ACT_WINDOW_END = 1'b1
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HW_CONTEXTS       = 3'd0,
    REG_HIGH_MARGIN       = 3'd1,
    REG_LOW_MARGIN        = 3'd2,
    REG_EXIT_SHIFT        = 3'd3,
    REG_EXIT_REQUIRED_MAX = 3'd4,
    REG_EXIT_REQUIRED_MIN = 3'd5,
    REG_SWITCH_LIMIT_HIGH = 3'd6,
    REG_SWITCH_LIMIT_LOW  = 3'd7
  } cfg_reg_t;

endpackage

### rtl/odet_if.sv
// Channel interfaces of the oversubscription detector: input, result, config.
`timescale 1ns / 1ps
interface odet_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [odet_pkg::CTX_W-1:0] running_count;

  modport source (output valid, action, running_count, input ready);
  modport sink   (input valid, action, running_count, output ready);
endinterface

interface odet_out_if;
  logic                        valid;
  logic                        ready;
  logic                        oversubscribed;
  logic                        mode_changed;
  logic                        hold_valid;
  logic [odet_pkg::HOLD_W-1:0] hold_exponent;

  modport source (output valid, oversubscribed, mode_changed, hold_valid, hold_exponent,
                  input ready);
  modport sink   (input valid, oversubscribed, mode_changed, hold_valid, hold_exponent,
                  output ready);
endinterface

interface odet_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [odet_pkg::CFG_IDX_W-1:0]  index;
  logic [odet_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/oversubscription_detector.sv
// Top level of the oversubscription detector.
//
// Usage:
//   in_ch   takes items: action 0 is a load sample with running_count,
//           action 1 marks the end of a one-second window.
//   out_ch  gives one result per item: mode flag after the item, whether a
//           sample toggled the mode, and a hold request with its exponent.
//   cfg_ch  writes the eight tuning registers by index; always ready.
//           Write only while no item is in flight.
// Path: an accepted item passes the input register, then the result
// register, before its result shows on out_ch.
// Throughput: one item per cycle unless out_ch stalls; the state update for
// an item is a single pass of compares, a shift and saturating counters
// between the registers. When out_ch stalls, the result register holds and
// in_ch.ready drops while the input register is full.
// Reset (rst_n low, synchronous) restores register defaults, clears mode,
// counters and both pipeline stages, and sets the exit requirement to 1.
`timescale 1ns / 1ps
`include "oversubscription_detector_macros.svh"
module oversubscription_detector (
  input logic         clk,
  input logic         rst_n,
  odet_in_if.sink     in_ch,
  odet_out_if.source  out_ch,
  odet_cfg_if.sink    cfg_ch
);

  // Configuration registers
  logic [odet_pkg::CTX_W-1:0]   hw_contexts_r;
  logic [odet_pkg::CTX_W-1:0]   high_margin_r;
  logic [odet_pkg::CTX_W-1:0]   low_margin_r;
  logic [odet_pkg::SHIFT_W-1:0] exit_shift_r;
  logic [odet_pkg::CNT_W-1:0]   exit_required_max_r;
  logic [odet_pkg::CNT_W-1:0]   exit_required_min_r;
  logic [odet_pkg::CNT_W-1:0]   switch_limit_high_r;
  logic [odet_pkg::CNT_W-1:0]   switch_limit_low_r;

  // Detector state
  logic                           mode_r, mode_nxt;
  logic [odet_pkg::CNT_W-1:0]     exit_required_r, exit_required_nxt;
  logic [odet_pkg::CNT_W-1:0]     quiet_seen_r, quiet_seen_nxt;
  logic [odet_pkg::CNT_W-1:0]     switch_count_r, switch_count_nxt;
  logic [odet_pkg::BACKOFF_W-1:0] backoff_r, backoff_nxt;

  // Pipeline registers
  logic                         in_valid_r;
  logic                         in_action_r;
  logic [odet_pkg::CTX_W-1:0]   in_count_r;
  logic                         out_valid_r;
  logic                         out_mode_r;
  logic                         out_changed_r, changed_nxt;
  logic                         out_hold_valid_r, hold_valid_nxt;
  logic [odet_pkg::HOLD_W-1:0]  out_hold_exp_r, hold_exp_nxt;

  logic advance;

  // Datapath intermediates
  logic signed [odet_pkg::CMP_W-1:0] runners;
  logic signed [odet_pkg::CMP_W-1:0] high_bound;
  logic signed [odet_pkg::CMP_W-1:0] low_bound;
  logic [odet_pkg::CNT_W+14:0]       raised;
  logic [odet_pkg::CNT_W-1:0]        switch_inc;
  logic [odet_pkg::CNT_W-1:0]        quiet_inc;

  // Handshake: move the input item into the result register when it is free
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.oversubscribed = out_mode_r;
  assign out_ch.mode_changed   = out_changed_r;
  assign out_ch.hold_valid     = out_hold_valid_r;
  assign out_ch.hold_exponent  = out_hold_exp_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_contexts_r       <= odet_pkg::RST_HW_CONTEXTS;
      high_margin_r       <= odet_pkg::RST_HIGH_MARGIN;
      low_margin_r        <= odet_pkg::RST_LOW_MARGIN;
      exit_shift_r        <= odet_pkg::RST_EXIT_SHIFT;
      exit_required_max_r <= odet_pkg::RST_EXIT_REQUIRED_MAX;
      exit_required_min_r <= odet_pkg::RST_EXIT_REQUIRED_MIN;
      switch_limit_high_r <= odet_pkg::RST_SWITCH_LIMIT_HIGH;
      switch_limit_low_r  <= odet_pkg::RST_SWITCH_LIMIT_LOW;
    end else if (cfg_ch.valid) begin
      case (odet_pkg::cfg_reg_t'(cfg_ch.index))
        odet_pkg::REG_HW_CONTEXTS:       hw_contexts_r <= cfg_ch.data[odet_pkg::CTX_W-1:0];
        odet_pkg::REG_HIGH_MARGIN:       high_margin_r <= cfg_ch.data[odet_pkg::CTX_W-1:0];
        odet_pkg::REG_LOW_MARGIN:        low_margin_r  <= cfg_ch.data[odet_pkg::CTX_W-1:0];
        odet_pkg::REG_EXIT_SHIFT:        exit_shift_r  <= cfg_ch.data[odet_pkg::SHIFT_W-1:0];
        odet_pkg::REG_EXIT_REQUIRED_MAX: exit_required_max_r <= cfg_ch.data;
        odet_pkg::REG_EXIT_REQUIRED_MIN: exit_required_min_r <= cfg_ch.data;
        odet_pkg::REG_SWITCH_LIMIT_HIGH: switch_limit_high_r <= cfg_ch.data;
        odet_pkg::REG_SWITCH_LIMIT_LOW:  switch_limit_low_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Bounds and saturating increments
  assign runners    = $signed({2'b00, in_count_r}) - 14'sd1;
  assign high_bound = $signed({2'b00, hw_contexts_r}) + $signed({2'b00, high_margin_r});
  assign low_bound  = $signed({2'b00, hw_contexts_r}) - $signed({2'b00, low_margin_r});
  assign raised     = {15'd0, exit_required_r} << exit_shift_r;
  assign switch_inc = (switch_count_r == odet_pkg::CNT_MAX) ? switch_count_r
                                                            : switch_count_r + 16'd1;
  assign quiet_inc  = (quiet_seen_r == odet_pkg::CNT_MAX) ? quiet_seen_r
                                                          : quiet_seen_r + 16'd1;

  // Next state and result for the item in the input register
  always_comb begin
    mode_nxt          = mode_r;
    exit_required_nxt = exit_required_r;
    quiet_seen_nxt    = quiet_seen_r;
    switch_count_nxt  = switch_count_r;
    backoff_nxt       = backoff_r;
    changed_nxt       = 1'b0;
    hold_valid_nxt    = 1'b0;
    hold_exp_nxt      = '0;
    if (odet_pkg::action_t'(in_action_r) == odet_pkg::ACT_SAMPLE) begin
      if (runners > high_bound) begin
        // Overloaded sample: enter the mode and raise the exit requirement
        quiet_seen_nxt = '0;
        if (!mode_r) begin
          exit_required_nxt = (raised > {15'd0, exit_required_max_r})
                              ? exit_required_max_r : raised[odet_pkg::CNT_W-1:0];
          mode_nxt         = 1'b1;
          switch_count_nxt = switch_inc;
          changed_nxt      = 1'b1;
        end
      end else if (runners < low_bound) begin
        if (mode_r) begin
          // Quiet sample while oversubscribed: count toward exit
          quiet_seen_nxt = quiet_inc;
          if (quiet_inc >= exit_required_r) begin
            mode_nxt         = 1'b0;
            switch_count_nxt = switch_inc;
            changed_nxt      = 1'b1;
          end
        end else begin
          // Quiet sample while normal: lower the requirement toward the floor
          exit_required_nxt = (exit_required_r <= exit_required_min_r)
                              ? exit_required_min_r : exit_required_r - 16'd1;
        end
      end
    end else begin
      // Window end: force the mode on too many switches, relax on few, clear the switch count
      if (switch_count_r > switch_limit_high_r) begin
        mode_nxt       = 1'b1;
        backoff_nxt    = (backoff_r == odet_pkg::BACKOFF_MAX) ? backoff_r
                                                              : backoff_r + 6'd1;
        hold_valid_nxt = 1'b1;
        hold_exp_nxt   = (backoff_r > {2'b00, odet_pkg::HOLD_LOG_MAX})
                         ? odet_pkg::HOLD_LOG_MAX : backoff_r[odet_pkg::HOLD_W-1:0];
      end else if (switch_count_r <= switch_limit_low_r) begin
        backoff_nxt = backoff_r >> 1;
      end
      switch_count_nxt = '0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      mode_r          <= 1'b0;
      exit_required_r <= odet_pkg::RST_EXIT_REQUIRED_MIN;
      quiet_seen_r    <= '0;
      switch_count_r  <= '0;
      backoff_r       <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r     <= 1'b1;
        mode_r          <= mode_nxt;
        exit_required_r <= exit_required_nxt;
        quiet_seen_r    <= quiet_seen_nxt;
        switch_count_r  <= switch_count_nxt;
        backoff_r       <= backoff_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_action_r <= in_ch.action;
      in_count_r  <= in_ch.running_count;
    end
    if (advance) begin
      out_mode_r       <= mode_nxt;
      out_changed_r    <= changed_nxt;
      out_hold_valid_r <= hold_valid_nxt;
      out_hold_exp_r   <= hold_exp_nxt;
    end
  end

  // Checks
  `ODET_ASSERT_IMP(a_hold_implies_mode, clk, rst_n,
                   out_valid_r && out_hold_valid_r, out_mode_r)
  `ODET_ASSERT_IMP(a_change_xor_hold, clk, rst_n,
                   out_valid_r, !(out_changed_r && out_hold_valid_r))
  `ODET_ASSERT_NXT(a_state_only_on_advance, clk, rst_n,
                   !advance, $stable(mode_r) && $stable(backoff_r))
  `ODET_ASSERT_NXT(a_window_clears_switches, clk, rst_n,
                   advance && in_action_r, switch_count_r == '0)
  `ODET_ASSERT_NXT(a_overload_clears_quiet, clk, rst_n,
                   advance && !in_action_r && (runners > high_bound), quiet_seen_r == '0)

endmodule
